// ----- src/gbts_pkg.sv -----
// Shared types and constants for the gap-buffer text store.
// Used by gbts_front, gbts_back and gap_buffer_text_store; depends on nothing.
package gbts_pkg;

  localparam int REQ_W    = 3;
  localparam int POS_W    = 13;
  localparam int CHAR_W   = 8;
  localparam int S_DATA_W = 24;  // req_type + position + char_in, whole bytes
  localparam int M_DATA_W = 40;  // status + char_out + text_length + cursor, padded

  // request codes on the input stream
  localparam logic [REQ_W-1:0] REQ_MOVE     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DEL_BACK = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_FWD  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd5;

  typedef enum logic [2:0] {
    OP_MOVE,
    OP_INSERT,
    OP_DEL_BACK,
    OP_DEL_FWD,
    OP_READ,
    OP_CLEAR,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] char_in;
  } cmd_t;

endpackage

// ----- src/gbts_front.sv -----
// Front end of the gap-buffer text store: takes input items, decodes the
// request code and holds decoded commands in a two-entry queue. Uses gbts_pkg.
module gbts_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata: req_type[2:0], position[15:3], char_in[23:16]
  input  logic [gbts_pkg::S_DATA_W-1:0] s_tdata,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output gbts_pkg::cmd_t                cmd
);
  import gbts_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       in_cmd;
  logic       push;
  logic       pop;

  always_comb begin
    in_cmd.position = s_tdata[REQ_W +: POS_W];
    in_cmd.char_in  = s_tdata[REQ_W+POS_W +: CHAR_W];
    unique case (s_tdata[REQ_W-1:0])
      REQ_MOVE:     in_cmd.op = OP_MOVE;
      REQ_INSERT:   in_cmd.op = OP_INSERT;
      REQ_DEL_BACK: in_cmd.op = OP_DEL_BACK;
      REQ_DEL_FWD:  in_cmd.op = OP_DEL_FWD;
      REQ_READ:     in_cmd.op = OP_READ;
      REQ_CLEAR:    in_cmd.op = OP_CLEAR;
      default:      in_cmd.op = OP_BAD;
    endcase
  end

  assign s_tready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = s_tvalid && s_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/gbts_back.sv -----
// Back end of the gap-buffer text store: text memory, gap pointers, the
// byte-per-cycle copy engine for cursor moves and the result register.
// Uses gbts_pkg; fed with decoded commands by gbts_front.
module gbts_back #(
  parameter int BUFFER_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  gbts_pkg::cmd_t                cmd,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: status[0], char_out[8:1], text_length[21:9], cursor[34:22], zeros above
  output logic [gbts_pkg::M_DATA_W-1:0] m_tdata
);
  import gbts_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int PW = $clog2(BUFFER_BYTES + 1);
  localparam int CW = (PW > POS_W) ? PW : POS_W;
  localparam logic [PW-1:0] BUF_P = PW'(BUFFER_BYTES);
  localparam logic [PW-1:0] ONE_P = PW'(1);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_MOVE} state_t;

  logic [CHAR_W-1:0] mem [BUFFER_BYTES];
  logic [CHAR_W-1:0] rd_data;

  state_t            state, state_next;
  logic [PW-1:0]     gap_low, gap_low_next;
  logic [PW-1:0]     gap_high, gap_high_next;
  logic [PW-1:0]     target, target_next;
  logic              move_left, move_left_next;
  logic              wr_pend, wr_pend_next;
  logic [AW-1:0]     wr_pend_addr, wr_pend_addr_next;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CHAR_W-1:0] wr_data;

  logic              load_out;
  logic              status_n;
  logic [CHAR_W-1:0] char_n;
  logic [PW-1:0]     len;
  logic [PW-1:0]     len_next;
  logic [CW-1:0]     pos_c;
  logic [CW-1:0]     len_c;
  logic [CW-1:0]     clamp_c;
  logic [PW-1:0]     clamp_p;
  logic [CW-1:0]     phys_c;
  logic              out_status;
  logic [CHAR_W-1:0] out_char;
  logic [POS_W-1:0]  out_len;
  logic [POS_W-1:0]  out_cursor;

  assign len      = BUF_P - (gap_high - gap_low);
  assign len_next = BUF_P - (gap_high_next - gap_low_next);
  assign pos_c    = CW'(cmd.position);
  assign len_c    = CW'(len);
  assign clamp_c  = (pos_c > len_c) ? len_c : pos_c;
  assign clamp_p  = PW'(clamp_c);
  // logical index to physical address: skip the gap when past the cursor
  assign phys_c   = (pos_c < CW'(gap_low)) ? pos_c : pos_c + CW'(gap_high - gap_low);

  always_comb begin
    state_next        = state;
    gap_low_next      = gap_low;
    gap_high_next     = gap_high;
    target_next       = target;
    move_left_next    = move_left;
    wr_pend_next      = wr_pend;
    wr_pend_addr_next = wr_pend_addr;
    rd_en             = 1'b0;
    rd_addr           = '0;
    wr_en             = 1'b0;
    wr_addr           = '0;
    wr_data           = '0;
    cmd_ready         = 1'b0;
    load_out          = 1'b0;
    status_n          = 1'b0;
    char_n            = '0;
    unique case (state)
      S_IDLE: begin
        cmd_ready = !m_tvalid || m_tready;
        if (cmd_valid && cmd_ready) begin
          unique case (cmd.op)
            OP_MOVE: begin
              if (clamp_p == gap_low) begin
                load_out = 1'b1;
              end else begin
                target_next    = clamp_p;
                move_left_next = (clamp_p < gap_low);
                wr_pend_next   = 1'b0;
                state_next     = S_MOVE;
              end
            end
            OP_INSERT: begin
              load_out = 1'b1;
              if (gap_low == gap_high) begin
                status_n = 1'b1;
              end else begin
                wr_en        = 1'b1;
                wr_addr      = AW'(gap_low);
                wr_data      = cmd.char_in;
                gap_low_next = gap_low + ONE_P;
              end
            end
            OP_DEL_BACK: begin
              load_out = 1'b1;
              if (gap_low == '0) status_n = 1'b1;
              else               gap_low_next = gap_low - ONE_P;
            end
            OP_DEL_FWD: begin
              load_out = 1'b1;
              if (gap_high == BUF_P) status_n = 1'b1;
              else                   gap_high_next = gap_high + ONE_P;
            end
            OP_READ: begin
              if (pos_c >= len_c) begin
                load_out = 1'b1;
                status_n = 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = phys_c[AW-1:0];
                state_next = S_READ;
              end
            end
            OP_CLEAR: begin
              load_out      = 1'b1;
              gap_low_next  = '0;
              gap_high_next = BUF_P;
            end
            default: begin
              load_out = 1'b1;
              status_n = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        load_out   = 1'b1;
        char_n     = rd_data;
        state_next = S_IDLE;
      end
      S_MOVE: begin
        // each write lands in the cycle after its read, from the registered read data
        if (wr_pend) begin
          wr_en   = 1'b1;
          wr_addr = wr_pend_addr;
          wr_data = rd_data;
        end
        if (gap_low != target) begin
          rd_en        = 1'b1;
          wr_pend_next = 1'b1;
          if (move_left) begin
            rd_addr           = AW'(gap_low - ONE_P);
            wr_pend_addr_next = AW'(gap_high - ONE_P);
            gap_low_next      = gap_low - ONE_P;
            gap_high_next     = gap_high - ONE_P;
          end else begin
            rd_addr           = AW'(gap_high);
            wr_pend_addr_next = AW'(gap_low);
            gap_low_next      = gap_low + ONE_P;
            gap_high_next     = gap_high + ONE_P;
          end
        end else begin
          wr_pend_next = 1'b0;
          load_out     = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gap_low   <= '0;
      gap_high  <= BUF_P;
      wr_pend   <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state        <= state_next;
      gap_low      <= gap_low_next;
      gap_high     <= gap_high_next;
      wr_pend      <= wr_pend_next;
      target       <= target_next;
      move_left    <= move_left_next;
      wr_pend_addr <= wr_pend_addr_next;
      if (load_out)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (load_out) begin
        out_status <= status_n;
        out_char   <= char_n;
        out_len    <= POS_W'(len_next);
        out_cursor <= POS_W'(gap_low_next);
      end
    end
  end

  assign m_tdata = {(M_DATA_W - 1 - CHAR_W - 2 * POS_W)'(0),
                    out_cursor, out_len, out_char, out_status};

endmodule

// ----- src/gap_buffer_text_store.sv -----
// Gap-buffer text store, top level: joins the request front end and the
// execution back end. Uses gbts_pkg, gbts_front and gbts_back.
//
// Holds up to BUFFER_BYTES bytes of text in a single-port-write, registered-read
// memory with a gap at the cursor. Each request item gives exactly one result
// item. Insert, delete back, delete forward, clear, refused requests and moves
// that do not change the cursor load their result straight from the idle state;
// a read first passes through the registered memory read (S_READ). A cursor move
// is taken in the idle state and goes to S_MOVE, where the copy engine moves one
// byte per cycle across the gap; then the last write lands and the result is loaded.
// A two-entry request queue lets new items be taken while the back end works or
// a result waits on m_tready. Memory contents are not cleared by reset or by
// the clear request; only the gap pointers are.
module gap_buffer_text_store #(
  parameter int BUFFER_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata: req_type[2:0], position[15:3], char_in[23:16]
  input  logic [gbts_pkg::S_DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: status[0], char_out[8:1], text_length[21:9], cursor[34:22], zeros above
  output logic [gbts_pkg::M_DATA_W-1:0] m_tdata
);
  import gbts_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  gbts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  gbts_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for gap_buffer_text_store: streams edit requests and checks every result
// item against a behavioral predictor or a fixed answer. Depends on gbts_pkg and the RTL.
module tb_top;
  import gbts_pkg::*;

  localparam int BUF_BYTES = 4096;
  // request codes the block does not define; they must be refused
  localparam logic [REQ_W-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE7 = 3'd7;
  localparam int RANDOM_PER_PHASE = 300;
  localparam int FILL_BYTES = 256;

  typedef struct packed {
    logic              status;
    logic [CHAR_W-1:0] char_out;
    logic [POS_W-1:0]  text_length;
    logic [POS_W-1:0]  cursor;
  } edit_result_t;

  // fixed answer for an item, used instead of the predicted one when known is set
  typedef struct packed {
    logic         known;
    edit_result_t res;
  } fixed_answer_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
    fixed_answer_t     answer;
  } edit_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  // predictor state: shadow of the byte memory and the gap edges
  logic [CHAR_W-1:0] text_shadow [BUF_BYTES];
  int gap_lo = 0;
  int gap_hi = BUF_BYTES;

  edit_result_t  pending_results [$];
  fixed_answer_t fixed_answers [$];
  int items_sent = 0;
  int results_seen = 0;
  int err_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  edit_row_t edit_rows [25] = '{
    // empty store: reads and deletes are refused, a move is clamped to zero; then inserts, reads, a move
    '{REQ_READ,     13'd0,    8'h00, '{1'b1, '{1'b1, 8'h00, 13'd0, 13'd0}}},
    '{REQ_DEL_BACK, 13'd0,    8'h00, '{1'b1, '{1'b1, 8'h00, 13'd0, 13'd0}}},
    '{REQ_DEL_FWD,  13'd0,    8'h00, '{1'b1, '{1'b1, 8'h00, 13'd0, 13'd0}}},
    '{REQ_MOVE,     13'd4096, 8'h00, '{1'b1, '{1'b0, 8'h00, 13'd0, 13'd0}}},
    '{REQ_INSERT,   13'd4095, 8'h00, '{1'b1, '{1'b0, 8'h00, 13'd1, 13'd1}}},
    '{REQ_INSERT,   13'd0,    8'hff, '{1'b1, '{1'b0, 8'h00, 13'd2, 13'd2}}},
    '{REQ_INSERT,   13'd0,    8'ha5, '{1'b1, '{1'b0, 8'h00, 13'd3, 13'd3}}},
    '{REQ_READ,     13'd0,    8'h00, '{1'b1, '{1'b0, 8'h00, 13'd3, 13'd3}}},
    '{REQ_READ,     13'd1,    8'h00, '{1'b1, '{1'b0, 8'hff, 13'd3, 13'd3}}},
    '{REQ_READ,     13'd3,    8'h00, '{1'b1, '{1'b1, 8'h00, 13'd3, 13'd3}}},
    '{REQ_MOVE,     13'd1,    8'h00, '{1'b1, '{1'b0, 8'h00, 13'd3, 13'd1}}},
    // read above the gap, edits around a mid-text cursor
    '{REQ_READ,     13'd2,    8'h00, '0},
    '{REQ_INSERT,   13'd0,    8'h5a, '0},
    '{REQ_DEL_BACK, 13'd0,    8'h00, '0},
    '{REQ_DEL_FWD,  13'd0,    8'h00, '0},
    '{REQ_MOVE,     13'd4096, 8'h00, '0},
    '{REQ_DEL_FWD,  13'd0,    8'h00, '0},
    '{REQ_MOVE,     13'd0,    8'h00, '0},
    '{REQ_READ,     13'd4096, 8'h00, '0},
    '{REQ_SPARE6,   13'd5,    8'h11, '0},
    '{REQ_SPARE7,   13'd4096, 8'hee, '0},
    '{REQ_READ,     13'd0,    8'h00, '0},
    // clear keeps memory but empties the text
    '{REQ_CLEAR,    13'd0,    8'h00, '{1'b1, '{1'b0, 8'h00, 13'd0, 13'd0}}},
    '{REQ_READ,     13'd0,    8'h00, '{1'b1, '{1'b1, 8'h00, 13'd0, 13'd0}}},
    '{REQ_INSERT,   13'd0,    8'h80, '0}
  };

  gap_buffer_text_store #(
    .BUFFER_BYTES(BUF_BYTES)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int text_len();
    return BUF_BYTES - (gap_hi - gap_lo);
  endfunction

  // applies one request to the shadow store and returns its result item
  function automatic edit_result_t apply_edit(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                                              logic [CHAR_W-1:0] ch);
    edit_result_t r;
    int target;
    int idx;
    r = '0;
    idx = int'(pos);
    case (req)
      REQ_MOVE: begin
        target = (idx > text_len()) ? text_len() : idx;
        while (gap_lo > target) begin
          gap_lo--;
          gap_hi--;
          text_shadow[gap_hi] = text_shadow[gap_lo];
        end
        while (gap_lo < target && gap_hi < BUF_BYTES) begin
          text_shadow[gap_lo] = text_shadow[gap_hi];
          gap_lo++;
          gap_hi++;
        end
      end
      REQ_INSERT: begin
        if (gap_lo >= gap_hi) begin
          r.status = 1'b1;
        end else begin
          text_shadow[gap_lo] = ch;
          gap_lo++;
        end
      end
      REQ_DEL_BACK: begin
        if (gap_lo == 0) r.status = 1'b1;
        else gap_lo--;
      end
      REQ_DEL_FWD: begin
        if (gap_hi >= BUF_BYTES) r.status = 1'b1;
        else gap_hi++;
      end
      REQ_READ: begin
        if (idx >= text_len()) r.status = 1'b1;
        else if (idx < gap_lo) r.char_out = text_shadow[idx];
        else r.char_out = text_shadow[idx + gap_hi - gap_lo];
      end
      REQ_CLEAR: begin
        gap_lo = 0;
        gap_hi = BUF_BYTES;
      end
      default: begin
        r.status = 1'b1;
      end
    endcase
    r.text_length = POS_W'(text_len());
    r.cursor = POS_W'(gap_lo);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [M_DATA_W-1:0] got,
                                 logic [M_DATA_W-1:0] want);
    $display("%0t ERROR %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // both handshakes are sampled here, before this edge's updates land
  always @(posedge clk) begin : monitor
    edit_result_t  pred;
    edit_result_t  got;
    edit_result_t  want;
    fixed_answer_t fixed;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pred = apply_edit(s_tdata[2:0], s_tdata[15:3], s_tdata[23:16]);
        fixed = fixed_answers.pop_front();
        pending_results.push_back(fixed.known ? fixed.res : pred);
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        got.status = m_tdata[0];
        got.char_out = m_tdata[8:1];
        got.text_length = m_tdata[21:9];
        got.cursor = m_tdata[34:22];
        if (pending_results.size() == 0) begin
          report_mismatch("result item with none expected", m_tdata, '0);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", M_DATA_W'(got.status), M_DATA_W'(want.status));
          if (got.char_out !== want.char_out)
            report_mismatch("char_out", M_DATA_W'(got.char_out), M_DATA_W'(want.char_out));
          if (got.text_length !== want.text_length)
            report_mismatch("text_length", M_DATA_W'(got.text_length),
                            M_DATA_W'(want.text_length));
          if (got.cursor !== want.cursor)
            report_mismatch("cursor", M_DATA_W'(got.cursor), M_DATA_W'(want.cursor));
          if (m_tdata[M_DATA_W-1:35] !== '0)
            report_mismatch("pad bits", M_DATA_W'(m_tdata[M_DATA_W-1:35]), '0);
        end
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // returns at the edge where the item is accepted
  task automatic send_req(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos, logic [CHAR_W-1:0] ch,
                          fixed_answer_t answer = '0);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    fixed_answers.push_back(answer);
    items_sent++;
    s_tvalid <= 1'b1;
    s_tdata <= {ch, pos, req};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [POS_W-1:0] near_cursor();
    int t;
    t = gap_lo + int'($urandom_range(16)) - 8;
    if (t < 0) t = 0;
    return POS_W'(t);
  endfunction

  task automatic send_random();
    int len;
    int roll;
    logic [REQ_W-1:0]  req;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
    len = text_len();
    roll = $urandom_range(99);
    ch = CHAR_W'($urandom);
    pos = POS_W'($urandom_range(BUF_BYTES));
    if (roll < 35) begin
      req = REQ_INSERT;
    end else if (roll < 43) begin
      req = REQ_DEL_BACK;
    end else if (roll < 50) begin
      req = REQ_DEL_FWD;
    end else if (roll < 70) begin
      req = REQ_MOVE;
      if ($urandom_range(4) != 0) pos = near_cursor();
    end else if (roll < 97) begin
      req = REQ_READ;
      if (len > 0 && $urandom_range(4) != 0) pos = POS_W'($urandom_range(len - 1));
    end else if (roll < 98) begin
      req = REQ_CLEAR;
    end else begin
      req = $urandom_range(1) ? REQ_SPARE6 : REQ_SPARE7;
    end
    send_req(req, pos, ch);
  endtask

  initial begin : stimulus
    int tx_pct [4];
    int rx_pct [4];
    tx_pct = '{0, 49, 0, 15};
    rx_pct = '{0, 0, 49, 15};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (edit_rows[i])
      send_req(edit_rows[i].req, edit_rows[i].pos, edit_rows[i].ch, edit_rows[i].answer);

    // fill part of the store, with a few reads and short moves mixed in
    send_req(REQ_CLEAR, '0, '0);
    for (int i = 0; i < FILL_BYTES; i++) begin
      send_req(REQ_INSERT, '0, CHAR_W'($urandom));
      case ($urandom_range(31))
        0: send_req(REQ_READ, POS_W'($urandom_range(i)), '0);
        1: send_req(REQ_MOVE, near_cursor(), '0);
        default: ;
      endcase
    end
    send_req(REQ_MOVE, 13'd4096, '0);
    send_req(REQ_INSERT, '0, 8'h3c);
    send_req(REQ_DEL_FWD, '0, '0);
    send_req(REQ_READ, 13'd4095, '0);
    send_req(REQ_READ, 13'd4096, '0);
    send_req(REQ_MOVE, 13'd0, '0);
    send_req(REQ_READ, 13'd0, '0);
    send_req(REQ_READ, 13'd4095, '0);
    send_req(REQ_INSERT, '0, 8'hc3);
    send_req(REQ_DEL_BACK, '0, '0);
    send_req(REQ_DEL_FWD, '0, '0);
    send_req(REQ_INSERT, '0, 8'h69);
    send_req(REQ_MOVE, 13'd2048, '0);
    send_req(REQ_READ, 13'd2047, '0);
    send_req(REQ_READ, 13'd2048, '0);
    send_req(REQ_DEL_BACK, '0, '0);
    send_req(REQ_CLEAR, '0, '0);

    for (int p = 0; p < 4; p++) begin
      tx_idle_pct = tx_pct[p];
      rx_stall_pct = rx_pct[p];
      repeat (RANDOM_PER_PHASE) send_random();
    end
    s_tvalid <= 1'b0;

    while (results_seen < items_sent) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("result items left over", M_DATA_W'(pending_results.size()), '0);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- gap_buffer_text_store.f -----
src/gbts_pkg.sv
src/gbts_front.sv
src/gbts_back.sv
src/gap_buffer_text_store.sv
tb/tb_top.sv
